FILE: design/swdhte_pkg.sv
// Package: shared types and constants of the SWD host transfer engine.
`timescale 1ns / 1ps

package swdhte_pkg;

    // Request byte and retry defaults
    localparam logic [7:0] REQ_TARGETSEL = 8'h99;
    localparam int         REQ_READ_POS  = 2;
    localparam logic [7:0] RETRY_RESET   = 8'd100;

    // Ack codes as assembled LSB first
    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    // Transfer status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_FAULT   = 3'd2;
    localparam logic [2:0] ST_NO_RESP = 3'd3;
    localparam logic [2:0] ST_PARITY  = 3'd4;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  request;
        logic [31:0] write_data;
        logic        line_in;
    } t_item;

    typedef struct packed {
        logic        drive_enable;
        logic        drive_bit;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] read_data;
    } t_result;

endpackage

FILE: design/swdhte_item_if.sv
// Interface: input request channel of the SWD host transfer engine.
`timescale 1ns / 1ps

interface swdhte_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  request;
    logic [31:0] write_data;
    logic        line_in;

    modport source (output valid, kind, request, write_data, line_in, input ready);
    modport sink   (input valid, kind, request, write_data, line_in, output ready);
endinterface

FILE: design/swdhte_res_if.sv
// Interface: result channel of the SWD host transfer engine.
`timescale 1ns / 1ps

interface swdhte_res_if;
    logic        valid;
    logic        ready;
    logic        drive_enable;
    logic        drive_bit;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;

    modport source (output valid, drive_enable, drive_bit, busy_res, done_res, status,
                    read_data, input ready);
    modport sink   (input valid, drive_enable, drive_bit, busy_res, done_res, status,
                    read_data, output ready);
endinterface

FILE: design/swdhte_cfg_if.sv
// Interface: configuration write channel (wait retry limit).
`timescale 1ns / 1ps

interface swdhte_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: design/swdhte_core.sv
// Module: per-tick SWD transfer sequencer (state and result logic).
`timescale 1ns / 1ps

module swdhte_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  swdhte_pkg::t_item   i_item,
    input  logic [7:0]          i_retry_limit,
    output swdhte_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_REQ   = 4'd1,
        PH_TRNA  = 4'd2,
        PH_ACK   = 4'd3,
        PH_SKIP  = 4'd4,
        PH_TRNW  = 4'd5,
        PH_WDATA = 4'd6,
        PH_RDATA = 4'd7,
        PH_RPAR  = 4'd8,
        PH_TRNR  = 4'd9,
        PH_IDLEB = 4'd10,
        PH_TRNRT = 4'd11
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [5:0]  r_bit_count, n_bit_count;
    logic [31:0] r_shift,     n_shift;
    logic        r_parity,    n_parity;
    logic [2:0]  r_ack,       n_ack;
    logic [7:0]  r_tries,     n_tries;
    logic [7:0]  r_held_req,  n_held_req;
    logic [31:0] r_held_wr,   n_held_wr;
    logic [5:0]  w_cnt_inc;

    swdhte_pkg::t_result n_res;

    assign w_cnt_inc = r_bit_count + 6'd1;

    // Next state and result for one item
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_parity    = r_parity;
        n_ack       = r_ack;
        n_tries     = r_tries;
        n_held_req  = r_held_req;
        n_held_wr   = r_held_wr;
        n_res       = '0;
        if (i_item.kind == swdhte_pkg::KIND_START) begin
            n_held_req     = i_item.request;
            n_held_wr      = i_item.write_data;
            n_tries        = '0;
            n_phase        = PH_REQ;
            n_bit_count    = '0;
            n_shift        = '0;
            n_parity       = 1'b0;
            n_ack          = '0;
            n_res.busy_res = 1'b1;
        end else if (r_phase != PH_IDLE) begin
            n_res.busy_res = 1'b1;
            unique case (r_phase)
                PH_REQ: begin
                    n_res.drive_enable = 1'b1;
                    n_res.drive_bit    = r_held_req[r_bit_count[2:0]];
                    n_bit_count        = w_cnt_inc;
                    if (w_cnt_inc >= 6'd8) begin
                        n_bit_count = '0;
                        n_phase     = (r_held_req == swdhte_pkg::REQ_TARGETSEL) ?
                                      PH_SKIP : PH_TRNA;
                    end
                end
                PH_TRNA: begin
                    n_phase = PH_ACK;
                end
                PH_ACK: begin
                    // ack bits arrive LSB first
                    n_ack       = r_ack | 3'({2'b00, i_item.line_in} << r_bit_count[1:0]);
                    n_bit_count = w_cnt_inc;
                    if (w_cnt_inc >= 6'd3) begin
                        n_bit_count = '0;
                        if (n_ack == swdhte_pkg::ACK_OK) begin
                            n_phase = r_held_req[swdhte_pkg::REQ_READ_POS] ?
                                      PH_RDATA : PH_TRNW;
                        end else if (n_ack == swdhte_pkg::ACK_WAIT) begin
                            if (r_tries < i_retry_limit) begin
                                n_tries = r_tries + 8'd1;
                                n_phase = PH_TRNRT;
                            end else begin
                                n_res.done_res = 1'b1;
                                n_res.status   = swdhte_pkg::ST_WAIT;
                                n_phase        = PH_IDLE;
                            end
                        end else begin
                            n_res.done_res = 1'b1;
                            n_res.status   = (n_ack == swdhte_pkg::ACK_FAULT) ?
                                             swdhte_pkg::ST_FAULT : swdhte_pkg::ST_NO_RESP;
                            n_phase        = PH_IDLE;
                        end
                    end
                end
                PH_TRNRT: begin
                    // restart the request after a WAIT
                    n_phase     = PH_REQ;
                    n_bit_count = '0;
                    n_shift     = '0;
                    n_parity    = 1'b0;
                    n_ack       = '0;
                end
                PH_SKIP: begin
                    n_bit_count = w_cnt_inc;
                    if (w_cnt_inc >= 6'd5) begin
                        n_bit_count = '0;
                        n_parity    = 1'b0;
                        n_phase     = PH_WDATA;
                    end
                end
                PH_TRNW: begin
                    n_parity    = 1'b0;
                    n_bit_count = '0;
                    n_phase     = PH_WDATA;
                end
                PH_WDATA: begin
                    n_res.drive_enable = 1'b1;
                    if (!r_bit_count[5]) begin
                        n_res.drive_bit = r_held_wr[r_bit_count[4:0]];
                        n_parity        = r_parity ^ r_held_wr[r_bit_count[4:0]];
                        n_bit_count     = w_cnt_inc;
                    end else begin
                        // parity bit closes the write
                        n_res.drive_bit = r_parity;
                        n_res.done_res  = 1'b1;
                        n_phase         = PH_IDLE;
                    end
                end
                PH_RDATA: begin
                    n_shift[r_bit_count[4:0]] = r_shift[r_bit_count[4:0]] | i_item.line_in;
                    n_parity    = r_parity ^ i_item.line_in;
                    n_bit_count = w_cnt_inc;
                    if (w_cnt_inc >= 6'd32) begin
                        n_bit_count = '0;
                        n_phase     = PH_RPAR;
                    end
                end
                PH_RPAR: begin
                    n_parity = r_parity ^ i_item.line_in;
                    n_phase  = PH_TRNR;
                end
                PH_TRNR: begin
                    n_phase = PH_IDLEB;
                end
                PH_IDLEB: begin
                    n_res.drive_enable = 1'b1;
                    n_res.done_res     = 1'b1;
                    n_res.status       = r_parity ? swdhte_pkg::ST_PARITY : swdhte_pkg::ST_OK;
                    n_res.read_data    = r_shift;
                    n_phase            = PH_IDLE;
                end
                default: begin
                    n_phase        = PH_IDLE;
                    n_res.busy_res = 1'b0;
                end
            endcase
        end
    end

    // Transfer state, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_parity    <= 1'b0;
            r_ack       <= '0;
            r_tries     <= '0;
            r_held_req  <= '0;
            r_held_wr   <= '0;
        end else if (i_push) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_parity    <= n_parity;
            r_ack       <= n_ack;
            r_tries     <= n_tries;
            r_held_req  <= n_held_req;
            r_held_wr   <= n_held_wr;
        end
    end

    assign o_res = n_res;

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && n_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("transfer did not return to idle after done");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 6'd32)
        else $error("bit counter out of range");

    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_res.status != swdhte_pkg::ST_OK) |-> n_res.done_res)
        else $error("status reported without done");
`endif

endmodule

FILE: design/swdhte_obuf.sv
// Module: result register with skid stage.
`timescale 1ns / 1ps

module swdhte_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  swdhte_pkg::t_result i_res,
    input  logic                i_take_ready,
    output logic                o_space,
    output logic                o_valid,
    output swdhte_pkg::t_result o_res
);

    logic                r_main_valid;
    logic                r_skid_valid;
    swdhte_pkg::t_result r_main;
    swdhte_pkg::t_result r_skid;
    logic                w_take;

    assign w_take  = r_main_valid && i_take_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

    // Main register feeds the port, skid catches a result during a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_main_valid || w_take) begin
                r_main       <= i_res;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid holds a result while the main register is empty");
`endif

endmodule

FILE: design/swd_host_transfer_engine_unit.sv
// SWD host transfer engine: the top level, wiring input, sequencer and result buffer.
//
// Usage:
//   i_in carries one request per item: a start (kind 0) latches the request
//   byte and write data, a tick (kind 1) is one SWCLK cycle and samples
//   line_in. Every accepted request yields exactly one result on o_out with
//   the SWDIO drive enable and level for that tick, busy, done, status and
//   read data.
//   i_cfg writes the wait retry limit (reset value 100); write it only while
//   no transfer is running. It is always ready.
//   Each result is registered in the result buffer before it appears on o_out.
//   Throughput: one request per clock while i_in.ready is high; the sequencer
//   state is updated in a single pass of logic from the registered transfer state.
//   When o_out stalls, one more result is held in a skid register and
//   i_in.ready then drops until the receiver takes a result.
//   Reset (i_rst_n low at a clock edge) returns the engine to idle, empties
//   the result buffer and restores the retry limit.
`timescale 1ns / 1ps

module swd_host_transfer_engine_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swdhte_item_if.sink  i_in,
    swdhte_cfg_if.sink   i_cfg,
    swdhte_res_if.source o_out
);

    logic [7:0]          r_limit;
    logic                w_push;
    logic                w_space;
    swdhte_pkg::t_item   w_item;
    swdhte_pkg::t_result w_core_res;
    swdhte_pkg::t_result w_out_res;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= swdhte_pkg::RETRY_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    // Input request handshake
    assign i_in.ready        = w_space;
    assign w_push            = i_in.valid && w_space;
    assign w_item.kind       = i_in.kind;
    assign w_item.request    = i_in.request;
    assign w_item.write_data = i_in.write_data;
    assign w_item.line_in    = i_in.line_in;

    swdhte_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_item        (w_item),
        .i_retry_limit (r_limit),
        .o_res         (w_core_res)
    );

    swdhte_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_res        (w_core_res),
        .i_take_ready (o_out.ready),
        .o_space      (w_space),
        .o_valid      (o_out.valid),
        .o_res        (w_out_res)
    );

    // Result port
    assign o_out.drive_enable = w_out_res.drive_enable;
    assign o_out.drive_bit    = w_out_res.drive_bit;
    assign o_out.busy_res     = w_out_res.busy_res;
    assign o_out.done_res     = w_out_res.done_res;
    assign o_out.status       = w_out_res.status;
    assign o_out.read_data    = w_out_res.read_data;

`ifndef SYNTHESIS
    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |=> (r_limit == $past(i_cfg.data)))
        else $error("retry limit write lost");
`endif

endmodule
